### sv/bspm_pkg.sv
// ----------------------------------------------------------------------------
// bspm_pkg
// Shared types and constants of the byte stream pattern masker.
// ----------------------------------------------------------------------------
package bspm_pkg;

    localparam int LEN_W      = 6;   // pattern_length register / run length
    localparam int CFG_DATA_W = 64;  // widest configuration register
    localparam int CFG_IDX_W  = 3;
    localparam int PAT_WORDS  = 4;

    localparam logic [7:0] MASK_BYTE = 8'h2A;  // '*'

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD3 = 3'd4;

    // command from the front to the back: one byte, or a run of asterisks
    typedef struct packed {
        logic             stars;  // 1: emit 'count' asterisks
        logic [7:0]       data;   // byte to emit when stars is 0
        logic [LEN_W-1:0] count;  // run length when stars is 1
        logic             last;   // final result of its input beat
    } t_cmd;

endpackage

### sv/bspm_front.sv
// ----------------------------------------------------------------------------
// bspm_front
// Holds the configuration and the sliding window; classifies each input beat
// and issues byte / asterisk-run commands.
// ----------------------------------------------------------------------------
module bspm_front #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bspm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bspm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_end_of_stream,
    output bspm_pkg::t_cmd                  o_cmd,
    output logic                            o_cmd_push,
    input  logic                            i_q_full
);
    import bspm_pkg::*;

    localparam int CW = $clog2(MAX_PATTERN + 1);

    localparam logic [1:0] WIN_HOLD  = 2'd0;
    localparam logic [1:0] WIN_SHIFT = 2'd1;  // drop oldest
    localparam logic [1:0] WIN_WRITE = 2'd2;  // append held byte
    localparam logic [1:0] WIN_SLIDE = 2'd3;  // append held byte, drop oldest

    logic [LEN_W-1:0]                       r_len;
    logic [PAT_WORDS-1:0][CFG_DATA_W-1:0]   r_pat;
    logic [7:0]                             r_win [MAX_PATTERN];
    logic [7:0]                             cand  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]                 hit;
    logic [CW-1:0]                          r_cnt, n_cnt, cnt_inc, len_eff;
    logic                                   r_in_vld;
    logic [7:0]                             r_in_byte;
    logic                                   r_in_eos;
    logic                                   done;
    logic                                   accept;
    logic [1:0]                             win_op;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
            r_pat <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEN:   r_len    <= i_cfg_data[LEN_W-1:0];
                CFG_WORD0: r_pat[0] <= i_cfg_data;
                CFG_WORD1: r_pat[1] <= i_cfg_data;
                CFG_WORD2: r_pat[2] <= i_cfg_data;
                CFG_WORD3: r_pat[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize saturates
    always_comb begin
        if (r_len == '0) begin
            len_eff = CW'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            len_eff = CW'(MAX_PATTERN);
        end else begin
            len_eff = r_len[CW-1:0];
        end
    end

    // window with the held byte dropped in at the fill position
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            cand[i] = (r_cnt == CW'(i)) ? r_in_byte : r_win[i];
            hit[i]  = (cand[i] == r_pat[i/8][(i%8)*8 +: 8]) || (CW'(i) >= len_eff);
        end
    end

    assign cnt_inc = r_cnt + CW'(1);

    always_comb begin
        n_cnt       = r_cnt;
        win_op      = WIN_HOLD;
        done        = 1'b0;
        o_cmd_push  = 1'b0;
        o_cmd.stars = 1'b0;
        o_cmd.data  = r_win[0];
        o_cmd.count = LEN_W'(len_eff);
        o_cmd.last  = 1'b0;
        if (r_in_vld) begin
            if (r_in_eos) begin
                if (r_cnt == '0) begin
                    done = 1'b1;
                end else if (!i_q_full) begin
                    o_cmd_push = 1'b1;
                    o_cmd.last = (r_cnt == CW'(1));
                    done       = (r_cnt == CW'(1));
                    win_op     = WIN_SHIFT;
                    n_cnt      = r_cnt - CW'(1);
                end
            end else if (r_cnt >= len_eff) begin
                // length shrunk: drain unmasked until one short of a window
                if (!i_q_full) begin
                    o_cmd_push = 1'b1;
                    win_op     = WIN_SHIFT;
                    n_cnt      = r_cnt - CW'(1);
                end
            end else if (cnt_inc != len_eff) begin
                win_op = WIN_WRITE;
                n_cnt  = cnt_inc;
                done   = 1'b1;
            end else if (!i_q_full) begin
                o_cmd_push = 1'b1;
                o_cmd.last = 1'b1;
                done       = 1'b1;
                if (&hit) begin
                    o_cmd.stars = 1'b1;
                    n_cnt       = '0;
                end else begin
                    o_cmd.data = cand[0];
                    win_op     = WIN_SLIDE;
                    n_cnt      = len_eff - CW'(1);
                end
            end
        end
    end

    assign o_full = r_in_vld && !done;
    assign accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (done) begin
                r_in_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_win
        logic [7:0] up_win, up_cand;
        if (g < MAX_PATTERN - 1) begin : g_mid
            assign up_win  = r_win[g+1];
            assign up_cand = cand[g+1];
        end else begin : g_top
            assign up_win  = r_win[g];
            assign up_cand = cand[g];
        end
        always_ff @(posedge i_clk) begin
            unique case (win_op)
                WIN_SHIFT: r_win[g] <= up_win;
                WIN_SLIDE: r_win[g] <= up_cand;
                WIN_WRITE: r_win[g] <= (r_cnt == CW'(g)) ? r_in_byte : r_win[g];
                WIN_HOLD:  r_win[g] <= r_win[g];
            endcase
        end
    end

endmodule

### sv/bspm_queue.sv
// ----------------------------------------------------------------------------
// bspm_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module bspm_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bspm_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_vld,
    output bspm_pkg::t_cmd o_head,
    input  logic           i_deq
);
    import bspm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [NW-1:0] r_num;
    logic          do_push, do_pop;

    assign o_full  = (r_num == NW'(DEPTH));
    assign o_vld   = (r_num != '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_deq && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_num  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_num <= r_num + NW'(1);
            end else if (do_pop && !do_push) begin
                r_num <= r_num - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

### sv/bspm_back.sv
// ----------------------------------------------------------------------------
// bspm_back
// Expands commands into result beats; owns the output register.
// ----------------------------------------------------------------------------
module bspm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bspm_pkg::t_cmd i_cmd,
    input  logic           i_cmd_vld,
    output logic           o_cmd_deq,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last
);
    import bspm_pkg::*;

    logic             r_out_vld;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic [LEN_W-1:0] r_rep, n_rep, rep_inc;
    logic             load, run_end;

    assign load    = !r_out_vld || i_pop;
    assign rep_inc = r_rep + LEN_W'(1);
    assign run_end = (rep_inc == i_cmd.count);

    always_comb begin
        n_rep     = r_rep;
        o_cmd_deq = 1'b0;
        if (load && i_cmd_vld) begin
            if (i_cmd.stars) begin
                n_rep     = run_end ? '0 : rep_inc;
                o_cmd_deq = run_end;
            end else begin
                o_cmd_deq = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_rep     <= '0;
        end else begin
            r_rep <= n_rep;
            if (load) begin
                r_out_vld <= i_cmd_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_cmd_vld) begin
            r_out_byte <= i_cmd.stars ? MASK_BYTE : i_cmd.data;
            r_out_last <= i_cmd.last && (!i_cmd.stars || run_end);
        end
    end

    assign o_empty    = !r_out_vld;
    assign o_out_byte = r_out_byte;
    assign o_run_last = r_out_last;

endmodule

### sv/byte_stream_pattern_masker_top.sv
// ----------------------------------------------------------------------------
// byte_stream_pattern_masker_top
// Replaces each leftmost, non-overlapping occurrence of the programmed
// pattern in a byte stream with asterisks; other bytes pass in order.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-----------------------------
//  input     | in        | push / full               | i_data_byte, i_end_of_stream
//  result    | out       | pop / empty               | o_out_byte, o_run_last
//  config    | in        | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
//  Steady state: one beat in and one beat out per cycle while neither side
//  stalls. A data beat gives at most one result, except a match, which gives
//  pattern-length asterisks, and a beat after the length was shortened, which
//  first drains the excess window bytes unmasked, then does the compare. An
//  end-of-stream beat drains the window bytes unmasked, oldest first. A result
//  passes through the input register, the command queue and the output register.
//  Reset is synchronous, active low, and clears window count, queue and
//  output register. Either side can stall freely; the command queue decouples
//  the window logic from the asterisk expansion.
// ----------------------------------------------------------------------------
module byte_stream_pattern_masker_top #(
    parameter int MAX_PATTERN = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [bspm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bspm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input beats
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_end_of_stream,
    // result beats
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_out_byte,
    output logic                            o_run_last
);
    import bspm_pkg::*;

    t_cmd fr_cmd;      // front -> queue
    t_cmd q_head;      // queue -> back
    logic fr_push;
    logic q_full;
    logic q_vld;
    logic bk_deq;

    // Front: window, compare against pattern, issue commands.
    bspm_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_push          (push),
        .o_full          (full),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_cmd           (fr_cmd),
        .o_cmd_push      (fr_push),
        .i_q_full        (q_full)
    );

    // Short command queue: lets a long asterisk run drain while the
    // front keeps filling the window.
    bspm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_cmd   (fr_cmd),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_head  (q_head),
        .i_deq   (bk_deq)
    );

    // Back: one result beat per cycle into the output register while the receiver pops.
    bspm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (q_head),
        .i_cmd_vld  (q_vld),
        .o_cmd_deq  (bk_deq),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

endmodule

### verif/byte_stream_pattern_masker_top_tb.sv
// ----------------------------------------------------------------------------
// byte_stream_pattern_masker_top_tb
// Self-checking bench for the byte stream pattern masker. A scoreboard keeps
// its own window and pattern registers and predicts the masked output bytes
// for every accepted input beat. A directed part and several random pattern
// phases are driven in bursts, against a receiver that stalls on its own
// schedule, including one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module byte_stream_pattern_masker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bspm_pkg::*;

    localparam int WIN_MAX       = 32;    // block built with MAX_PATTERN = 32
    localparam int TOTAL_BEATS   = 150;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_AT       = 30;    // input beats before the long hold-off
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all

    // one expected result beat
    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
    } t_masked_beat;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the pattern registers and the sliding window.
    // ------------------------------------------------------------------------
    class masked_stream_checker;
        bit [LEN_W-1:0]      pat_len = 1;
        bit [CFG_DATA_W-1:0] pat_words [PAT_WORDS];
        bit [7:0]            window [WIN_MAX];
        int                  win_count;
        bit [7:0]            run [$];
        t_masked_beat        expected_bytes [$];
        int                  n_errors;

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_LEN:   pat_len      = value[LEN_W-1:0];
                CFG_WORD0: pat_words[0] = value;
                CFG_WORD1: pat_words[1] = value;
                CFG_WORD2: pat_words[2] = value;
                CFG_WORD3: pat_words[3] = value;
                default: ;
            endcase
        endfunction

        // oldest window byte leaves unmasked
        function void shift_out();
            run.push_back(window[0]);
            for (int k = 1; k < win_count; k++)
                window[k-1] = window[k];
            win_count--;
        endfunction

        function void note_beat(bit [7:0] data_byte, bit end_of_stream);
            int len;
            bit hit;
            len = (pat_len == 0) ? 1 : ((pat_len > WIN_MAX) ? WIN_MAX : int'(pat_len));
            run.delete();
            if (end_of_stream) begin
                while (win_count > 0)
                    shift_out();
            end else begin
                // a shortened length drains the excess first
                while (win_count > len - 1)
                    shift_out();
                window[win_count] = data_byte;
                win_count++;
                if (win_count == len) begin
                    hit = 1'b1;
                    for (int k = 0; k < len; k++)
                        if (window[k] != pat_words[k/8][8*(k%8) +: 8])
                            hit = 1'b0;
                    if (hit) begin
                        repeat (len) run.push_back(MASK_BYTE);
                        win_count = 0;
                    end else begin
                        shift_out();
                    end
                end
            end
            foreach (run[k])
                expected_bytes.push_back('{run[k], k == run.size() - 1});
        endfunction

        function void check_beat(logic [7:0] out_byte, logic run_last);
            t_masked_beat want;
            if (expected_bytes.size() == 0) begin
                $error("result beat with nothing expected: out_byte=%02h run_last=%0b",
                       out_byte, run_last);
                n_errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (out_byte !== want.out_byte) begin
                $error("out_byte: expected %02h, actual %02h", want.out_byte, out_byte);
                n_errors++;
            end
            if (run_last !== want.run_last) begin
                $error("run_last: expected %0b, actual %0b", want.run_last, run_last);
                n_errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    logic [7:0]            i_data_byte;
    logic                  i_end_of_stream;
    logic                  empty;
    logic                  pop;
    logic [7:0]            o_out_byte;
    logic                  o_run_last;

    byte_stream_pattern_masker_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .empty           (empty),
        .pop             (pop),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last)
    );

    masked_stream_checker sb;
    int in_beats;      // accepted input beats
    int stall_cycles;  // consecutive cycles without any handshake
    int burst_left;    // beats left in the sender's current burst
    bit progress;

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, inputs having moved
    // at the falling edge. Config writes only happen while the block is idle,
    // so updating the scoreboard registers here keeps it in step.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (i_cfg_we) begin
                sb.write_reg(i_cfg_idx, i_cfg_data);
                progress = 1'b1;
            end
            if (pop && !empty) begin
                sb.check_beat(o_out_byte, o_run_last);
                progress = 1'b1;
            end
            if (push && !full) begin
                sb.note_beat(i_data_byte, i_end_of_stream);
                in_beats++;
                progress = 1'b1;
            end
            stall_cycles = progress ? 0 : stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // One input beat. Bursts of random length, separated by short gaps; push
    // stays high across a burst and while the block reports full.
    task automatic send_beat(input logic [7:0] data_byte, input logic eos);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        push            <= 1'b1;
        i_data_byte     <= data_byte;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_beat(s[k], 1'b0);
    endtask

    // Stop offering beats, wait for every expected result, then let the
    // pipeline drain beats that produced nothing.
    task automatic quiesce();
        @(negedge i_clk);
        push <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Writes all five registers once the block is idle. The window keeps its
    // contents, so a new length or pattern can land mid-stream.
    task automatic load_pattern(input logic [LEN_W-1:0] len,
                                input logic [CFG_DATA_W-1:0] w0, w1, w2, w3);
        quiesce();
        write_reg(CFG_LEN,   {{(CFG_DATA_W-LEN_W){1'b0}}, len});
        write_reg(CFG_WORD0, w0);
        write_reg(CFG_WORD1, w1);
        write_reg(CFG_WORD2, w2);
        write_reg(CFG_WORD3, w3);
    endtask

    // One random phase: new length and pattern, then mostly whole copies and
    // prefixes of the pattern, with pattern-alphabet bytes, noise and the odd
    // end-of-stream beat mixed in. len_code < 0 picks the length at random.
    task automatic random_phase(input int len_code, input int beats);
        bit [7:0]            pat [WIN_MAX];
        bit [CFG_DATA_W-1:0] words [PAT_WORDS];
        int                  len;
        int                  sent;
        int                  cut;
        int                  pick;
        bit                  narrow;
        if (len_code < 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                len_code = $urandom_range(1, 4);
            else if (pick < 65)
                len_code = $urandom_range(5, 12);
            else if (pick < 80)
                len_code = $urandom_range(13, 31);
            else if (pick < 90)
                len_code = WIN_MAX;
            else
                len_code = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(33, 63);
        end
        len = (len_code == 0) ? 1 : ((len_code > WIN_MAX) ? WIN_MAX : len_code);
        // a two-letter alphabet gives self-overlapping patterns
        narrow = $urandom_range(0, 1);
        foreach (words[w])
            words[w] = {$urandom, $urandom};
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0)
                pat[k] = MASK_BYTE;
            else if (narrow)
                pat[k] = 8'h61 + 8'($urandom_range(0, 1));
            else
                pat[k] = 8'($urandom);
            words[k/8][8*(k%8) +: 8] = pat[k];
        end
        load_pattern(LEN_W'(len_code), words[0], words[1], words[2], words[3]);

        sent = 0;
        while (sent < beats) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // whole copy or a broken-off prefix
                cut = (pick < 45) ? len : $urandom_range(0, len - 1);
                for (int k = 0; k < cut; k++)
                    send_beat(pat[k], 1'b0);
                sent += cut;
            end else if (pick < 85) begin
                send_beat(pat[$urandom_range(0, len - 1)], 1'b0);
                sent++;
            end else if (pick < 95) begin
                send_beat(8'($urandom), 1'b0);
                sent++;
            end else begin
                send_beat(8'($urandom), 1'b1);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: pop follows a repeating schedule of segments (always ready,
    // coin flip, three in four, mostly ready). Once, after enough input beats,
    // it holds off for a long stretch so the block fills and asserts full.
    // ------------------------------------------------------------------------
    initial begin
        int rx_tick;
        bit held_off;
        rx_tick  = 0;
        held_off = 1'b0;
        pop      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && in_beats >= HOLD_AT) begin
                held_off = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                rx_tick++;
                case ((rx_tick / 64) % 4)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 1) == 0);
                    2:       pop <= (rx_tick % 4 != 0);
                    default: pop <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Watchdog: a stuck handshake ends the run
    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb              = new();
        in_beats        = 0;
        stall_cycles    = 0;
        burst_left      = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_LEN;
        i_cfg_data      = '0;
        push            = 1'b0;
        i_data_byte     = 8'h00;
        i_end_of_stream = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: length 1, pattern byte 00 -> every 00 is masked;
        // an end of stream on an empty window gives nothing
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(MASK_BYTE, 1'b0);
        send_beat(8'h5A, 1'b1);

        // "abc": a false start, a match, then a partial flushed at the end
        load_pattern(6'd3, 64'h0000_0000_0063_6261, '1, '1, '1);
        send_text("aabcab");
        send_beat(8'hA5, 1'b1);

        // length zero acts as one
        load_pattern(6'd0, '1, '0, '0, '0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFE, 1'b0);

        // fill four of five, then shorten to two and swap the pattern: the
        // next byte first pushes the three oldest out unmasked, then matches
        load_pattern(6'd5, 64'h0000_006F_6C6C_6568, '0, '0, '0);
        send_text("hell");
        load_pattern(6'd2, 64'h0000_0000_0000_786C, '0, '0, '0);
        send_text("x");

        // window holds a whole match after shortening: end of stream still
        // passes it through unmasked
        load_pattern(6'd3, 64'h0000_0000_0063_6261, '0, '0, '0);
        send_text("ab");
        load_pattern(6'd2, 64'h0000_0000_0000_6261, '0, '0, '0);
        send_beat(8'h3C, 1'b1);

        // length one: every beat gives a result, so while the receiver holds
        // off the queue and output register fill and full comes up
        load_pattern(6'd1, 64'h0000_0000_0000_0041, '0, '0, '0);
        while (in_beats < HOLD_AT + 20)
            send_beat(8'h40 + 8'($urandom_range(0, 3)), 1'b0);

        // random phases; the first two take the register extreme and the
        // longest pattern
        random_phase(63, $urandom_range(12, 28));
        random_phase(WIN_MAX, $urandom_range(12, 28));
        while (in_beats < TOTAL_BEATS)
            random_phase(-1, $urandom_range(12, 28));

        quiesce();
        if (sb.n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
